FILE: hw/rtl/fifo_evict_associative_table_macros.svh
// ----------------------------------------------------------------------------
// fifo_evict_associative_table assertion macros
// Shared concurrent assertion forms for the associative table RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_EVICT_ASSOCIATIVE_TABLE_MACROS_SVH
`define FIFO_EVICT_ASSOCIATIVE_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FEAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FEAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/feat_pkg.sv
// ----------------------------------------------------------------------------
// feat_pkg
// Widths, action codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package feat_pkg;

	localparam int FEAT_ENTRIES = 32;
	localparam int KEY_W        = 48;
	localparam int PROT_W       = 48;
	localparam int FLAGS_W      = 32;

	localparam logic ACT_CAPTURE = 1'b0;
	localparam logic ACT_LOOKUP  = 1'b1;

	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
		logic write;
		logic load_out;
	} feat_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic skip_write;
	} feat_sts_t;

endpackage

FILE: hw/rtl/fifo_evict_associative_table.sv
// ----------------------------------------------------------------------------
// fifo_evict_associative_table
// Associative table keyed by a 48-bit handle with oldest-first replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: action, key_handle,
//   protection_in, flags_in. Action capture refreshes or inserts an entry,
//   action lookup returns hit, flags_out and protection_out.
//   Output channel (out_valid / out_stall) returns one result per request.
//   After the accept edge the key store read port sweeps the filled entries,
//   one per cycle through the registered read stage, stopping on the first
//   match or after the last filled entry; a null key skips the sweep. A
//   capture with a non-null key then writes the table, and the result is
//   loaded into the output register.
//   One request is in work at a time; in_stall is low only while idle, so the
//   next request is taken only after the last result is loaded for output.
//   A result waiting under out_stall does not block the next request; that
//   request holds before its own hand-off until the output register frees.
//   Reset empties the table (fill count and cursor to zero, no clearing pass)
//   and drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_evict_associative_table
	import feat_pkg::*;
#(
	parameter int ENTRIES = FEAT_ENTRIES
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [KEY_W-1:0]   key_handle,
	input  logic [PROT_W-1:0]  protection_in,
	input  logic [FLAGS_W-1:0] flags_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic               ignored,
	output logic               evicted,
	output logic [FLAGS_W-1:0] flags_out,
	output logic [PROT_W-1:0]  protection_out
);

	feat_cmd_t cmd;
	feat_sts_t sts;

	feat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	feat_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (action),
		.key_handle     (key_handle),
		.protection_in  (protection_in),
		.flags_in       (flags_in),
		.cmd            (cmd),
		.sts            (sts),
		.hit            (hit),
		.ignored        (ignored),
		.evicted        (evicted),
		.flags_out      (flags_out),
		.protection_out (protection_out)
	);

endmodule

FILE: hw/rtl/feat_ctrl.sv
// ----------------------------------------------------------------------------
// feat_ctrl
// Request sequencing: accept, key scan, table write, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feat_ctrl
	import feat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output feat_cmd_t cmd,
	input  feat_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					cmd.finish = 1'b1;
					state_d    = sts.skip_write ? ST_DONE : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/feat_dp.sv
// ----------------------------------------------------------------------------
// feat_dp
// Table memories, pipelined key scan, fill count, replacement cursor and
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fifo_evict_associative_table_macros.svh"

module feat_dp
	import feat_pkg::*;
#(
	parameter int ENTRIES = FEAT_ENTRIES
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               action,
	input  logic [KEY_W-1:0]   key_handle,
	input  logic [PROT_W-1:0]  protection_in,
	input  logic [FLAGS_W-1:0] flags_in,
	input  feat_cmd_t          cmd,
	output feat_sts_t          sts,
	output logic               hit,
	output logic               ignored,
	output logic               evicted,
	output logic [FLAGS_W-1:0] flags_out,
	output logic [PROT_W-1:0]  protection_out
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	logic [KEY_W-1:0]   key_mem   [ENTRIES];
	logic [PROT_W-1:0]  prot_mem  [ENTRIES];
	logic [FLAGS_W-1:0] flags_mem [ENTRIES];

	// latched request
	logic               act_q;
	logic [KEY_W-1:0]   key_q;
	logic [PROT_W-1:0]  prot_q;
	logic [FLAGS_W-1:0] flags_q;

	// scan pipeline
	logic [CW-1:0]      rd_idx_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [PROT_W-1:0]  prot_s1;
	logic [FLAGS_W-1:0] flags_s1;

	// table bookkeeping
	logic [CW-1:0]      used_q;
	logic [AW-1:0]      cursor_q;

	// resolved result
	logic               hit_q;
	logic               ign_q;
	logic               evict_q;
	logic [AW-1:0]      found_q;
	logic [FLAGS_W-1:0] res_flags_q;
	logic [PROT_W-1:0]  res_prot_q;

	// output registers
	logic               hit_out_q;
	logic               ign_out_q;
	logic               evict_out_q;
	logic [FLAGS_W-1:0] flags_out_q;
	logic [PROT_W-1:0]  prot_out_q;

	logic          null_key;
	logic          is_lookup;
	logic          match;
	logic          rd_en;
	logic          table_full;
	logic [AW-1:0] wr_addr;

	assign null_key   = (key_q == '0);
	assign is_lookup  = (act_q == ACT_LOOKUP);
	assign match      = vld_s1 && (key_s1 == key_q);
	assign table_full = (used_q == FULL);
	assign rd_en      = cmd.scan && !null_key && !match && (rd_idx_q < used_q);

	assign sts.scan_done  = null_key || match || (!vld_s1 && (rd_idx_q == used_q));
	assign sts.skip_write = null_key || is_lookup;

	always_comb begin
		if (hit_q) begin
			wr_addr = found_q;
		end else if (!table_full) begin
			wr_addr = used_q[AW-1:0];
		end else begin
			wr_addr = cursor_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q   <= action;
			key_q   <= key_handle;
			prot_q  <= protection_in;
			flags_q <= flags_in;
		end
		if (rd_en) begin
			idx_s1   <= rd_idx_q[AW-1:0];
			key_s1   <= key_mem[rd_idx_q[AW-1:0]];
			prot_s1  <= prot_mem[rd_idx_q[AW-1:0]];
			flags_s1 <= flags_mem[rd_idx_q[AW-1:0]];
		end
		if (cmd.write) begin
			if (!hit_q) begin
				key_mem[wr_addr] <= key_q;
			end
			prot_mem[wr_addr]  <= prot_q;
			flags_mem[wr_addr] <= flags_q;
		end
		if (cmd.finish) begin
			found_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			used_q      <= '0;
			cursor_q    <= '0;
			hit_q       <= 1'b0;
			ign_q       <= 1'b0;
			evict_q     <= 1'b0;
			res_flags_q <= '0;
			res_prot_q  <= '0;
			hit_out_q   <= 1'b0;
			ign_out_q   <= 1'b0;
			evict_out_q <= 1'b0;
			flags_out_q <= '0;
			prot_out_q  <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (cmd.accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.finish) begin
				hit_q       <= match && !null_key;
				ign_q       <= null_key;
				evict_q     <= !null_key && !is_lookup && !match && table_full;
				res_flags_q <= (match && is_lookup) ? flags_s1 : '0;
				res_prot_q  <= (match && is_lookup) ? prot_s1 : '0;
			end
			if (cmd.write && !hit_q) begin
				if (!table_full) begin
					used_q <= used_q + 1'b1;
				end else begin
					cursor_q <= (cursor_q == LAST) ? '0 : cursor_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				hit_out_q   <= hit_q;
				ign_out_q   <= ign_q;
				evict_out_q <= evict_q;
				flags_out_q <= res_flags_q;
				prot_out_q  <= res_prot_q;
			end
		end
	end

	assign hit            = hit_out_q;
	assign ignored        = ign_out_q;
	assign evicted        = evict_out_q;
	assign flags_out      = flags_out_q;
	assign protection_out = prot_out_q;

	`FEAT_ASSERT_IMP(a_used_range, clk, arst_n, 1'b1, used_q <= FULL, "fill count beyond table size")
	`FEAT_ASSERT_NXT(a_used_step, clk, arst_n, 1'b1, (used_q == $past(used_q)) || (used_q == $past(used_q) + 1'b1), "fill count moved by more than one")
	`FEAT_ASSERT_IMP(a_cursor_full, clk, arst_n, cursor_q != '0, table_full, "replacement cursor moved before table filled")
	`FEAT_ASSERT_IMP(a_evict_excl, clk, arst_n, evict_out_q, !hit_out_q && !ign_out_q, "eviction reported with hit or null key")

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the associative handle table with oldest-first
// replacement. A driver feeds capture and lookup requests in random bursts,
// a monitor keeps a shadow table that predicts every result and checks the
// returned fields in order while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import feat_pkg::*;

	localparam int RANDOM_REQUESTS = 550;
	localparam int POOL_SIZE       = 48;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 3 * (FEAT_ENTRIES + 4);

	typedef struct packed {
		logic               action;
		logic [KEY_W-1:0]   key;
		logic [PROT_W-1:0]  prot;
		logic [FLAGS_W-1:0] flags;
	} table_request_t;

	typedef struct packed {
		logic               hit;
		logic               ignored;
		logic               evicted;
		logic [FLAGS_W-1:0] flags;
		logic [PROT_W-1:0]  prot;
	} table_result_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_stall;
	logic               action        = ACT_CAPTURE;
	logic [KEY_W-1:0]   key_handle    = '0;
	logic [PROT_W-1:0]  protection_in = '0;
	logic [FLAGS_W-1:0] flags_in      = '0;
	logic               out_valid;
	logic               out_stall     = 1'b0;
	logic               hit;
	logic               ignored;
	logic               evicted;
	logic [FLAGS_W-1:0] flags_out;
	logic [PROT_W-1:0]  protection_out;

	fifo_evict_associative_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.key_handle    (key_handle),
		.protection_in (protection_in),
		.flags_in      (flags_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.ignored       (ignored),
		.evicted       (evicted),
		.flags_out     (flags_out),
		.protection_out(protection_out)
	);

	always #4 clk = ~clk;

	// shadow table
	logic [KEY_W-1:0]   shadow_keys  [FEAT_ENTRIES];
	logic [PROT_W-1:0]  shadow_prots [FEAT_ENTRIES];
	logic [FLAGS_W-1:0] shadow_flags [FEAT_ENTRIES];
	int                 shadow_used   = 0;
	int                 shadow_cursor = 0;

	table_request_t     request_queue[$];
	table_result_t      expected_results[$];
	logic [KEY_W-1:0]   key_pool[POOL_SIZE];

	int sent_count     = 0;
	int taken_count    = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int gap_left       = 0;
	int burst_left     = 0;
	int stall_mode     = 0;
	int stall_left     = 0;

	function automatic table_result_t predict_table_result(table_request_t req);
		table_result_t res;
		int            slot;
		res  = '0;
		slot = -1;
		if (req.key == '0) begin
			res.ignored = 1'b1;
			return res;
		end
		for (int i = 0; i < shadow_used; i++) begin
			if (slot < 0 && shadow_keys[i] == req.key)
				slot = i;
		end
		if (req.action == ACT_LOOKUP) begin
			if (slot >= 0) begin
				res.hit   = 1'b1;
				res.flags = shadow_flags[slot];
				res.prot  = shadow_prots[slot];
			end
			return res;
		end
		if (slot >= 0) begin
			res.hit = 1'b1;
		end else if (shadow_used < FEAT_ENTRIES) begin
			slot = shadow_used;
			shadow_used++;
		end else begin
			slot          = shadow_cursor;
			shadow_cursor = (shadow_cursor + 1 >= FEAT_ENTRIES) ? 0 : shadow_cursor + 1;
			res.evicted   = 1'b1;
		end
		shadow_keys[slot]  = req.key;
		shadow_prots[slot] = req.prot;
		shadow_flags[slot] = req.flags;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_request(logic act, logic [KEY_W-1:0] key, logic [PROT_W-1:0] prot,
			logic [FLAGS_W-1:0] flags);
		request_queue.push_back('{act, key, prot, flags});
	endtask

	function automatic logic [47:0] random48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// stimulus
	initial begin
		logic [KEY_W-1:0]   k;
		logic [PROT_W-1:0]  p;
		logic [FLAGS_W-1:0] f;
		int                 pick;

		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i < POOL_SIZE / 2 || i == 0)
				k = random48();
			else
				k = key_pool[$urandom_range(0, i - 1)] ^ (48'd1 << $urandom_range(0, KEY_W - 1));
			key_pool[i] = (k == '0) ? 48'd1 : k;
		end

		// null keys, misses on an empty table, inserts, refreshes, field extremes
		add_request(ACT_CAPTURE, '0, '1, '1);
		add_request(ACT_LOOKUP, '0, '1, '1);
		add_request(ACT_LOOKUP, 48'd1, '0, '0);
		add_request(ACT_CAPTURE, '1, '1, '1);
		add_request(ACT_LOOKUP, '1, '0, '0);
		add_request(ACT_CAPTURE, 48'd1, '0, '0);
		add_request(ACT_LOOKUP, 48'd1, '1, '1);
		add_request(ACT_CAPTURE, '1, '0, '0);
		add_request(ACT_LOOKUP, '1, '1, '1);
		add_request(ACT_CAPTURE, 48'h8000_0000_0000, 48'd1, 32'h8000_0000);
		add_request(ACT_LOOKUP, 48'h8000_0000_0000, '0, '0);
		add_request(ACT_LOOKUP, 48'd2, '0, '0);
		add_request(ACT_CAPTURE, 48'd1, 48'h5555_5555_5555, 32'haaaa_aaaa);
		add_request(ACT_LOOKUP, 48'd1, '0, '0);
		add_request(ACT_CAPTURE, 48'h7fff_ffff_ffff, 48'haaaa_aaaa_aaaa, 32'h5555_5555);
		add_request(ACT_LOOKUP, 48'h7fff_ffff_ffff, '0, '0);
		add_request(ACT_CAPTURE, '0, '0, '0);

		// mostly pooled keys so the table fills, wraps and refreshes
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				k = '0;
			else if (pick < 14)
				k = random48();
			else
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			case ($urandom_range(0, 7))
				0:       p = '0;
				1:       p = '1;
				default: p = random48();
			endcase
			case ($urandom_range(0, 7))
				0:       f = '0;
				1:       f = '1;
				default: f = $urandom;
			endcase
			add_request($urandom_range(0, 1) ? ACT_LOOKUP : ACT_CAPTURE, k, p, f);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (request_queue.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		table_request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && taken_count != sent_count) begin
			// hold until taken
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (request_queue.size() != 0) begin
			req           = request_queue.pop_front();
			in_valid      <= 1'b1;
			action        <= req.action;
			key_handle    <= req.key;
			protection_in <= req.prot;
			flags_in      <= req.flags;
			sent_count    <= sent_count + 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= $urandom_range(0, 1);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// result monitor and request capture
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result hit", 64'(hit), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", 64'(hit), 64'(want.hit));
					if (ignored !== want.ignored)
						report_mismatch("ignored", 64'(ignored), 64'(want.ignored));
					if (evicted !== want.evicted)
						report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
					if (flags_out !== want.flags)
						report_mismatch("flags_out", 64'(flags_out), 64'(want.flags));
					if (protection_out !== want.prot)
						report_mismatch("protection_out", 64'(protection_out), 64'(want.prot));
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_table_result(
					'{action, key_handle, protection_in, flags_in}));
				taken_count <= taken_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

endmodule
